// ===== rtl/ewald_reciprocal_delta_core_assert.svh =====
// Assertion macros for the reciprocal-space core.
`ifndef EWALD_RECIPROCAL_DELTA_CORE_ASSERT_SVH
`define EWALD_RECIPROCAL_DELTA_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define ERD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define ERD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/erd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package erd_pkg;

    localparam int MAX_KVECTORS = 512;
    localparam int MAX_K        = 8;
    localparam int ADDR_W       = $clog2(MAX_KVECTORS);
    localparam int KCOUNT_W     = 10;
    localparam int CNT_W        = $clog2(MAX_KVECTORS + 1);
    localparam int CMP_W        = (CNT_W > KCOUNT_W) ? CNT_W : KCOUNT_W;
    localparam int TAB_W        = 29;
    localparam int SF_W         = 64;
    localparam int CW           = 18;
    localparam int STEPS        = 14;
    localparam int CORDIC_X0    = 19898;
    localparam int DLAT         = STEPS + 4;
    localparam int ELAT         = 5;

    localparam logic [2:0] FN_LOAD   = 3'd0;
    localparam logic [2:0] FN_DELTA  = 3'd1;
    localparam logic [2:0] FN_EVAL   = 3'd2;
    localparam logic [2:0] FN_COMMIT = 3'd3;
    localparam logic [2:0] FN_REJECT = 3'd4;

    localparam logic [1:0] MK_MOVE   = 2'd0;
    localparam logic [1:0] MK_INSERT = 2'd1;
    localparam logic [1:0] MK_REMOVE = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef logic signed [CW-1:0] t_cw;

    function automatic t_cw angle_step(input int i);
        case (i)
            0:       return t_cw'(8192);
            1:       return t_cw'(4836);
            2:       return t_cw'(2555);
            3:       return t_cw'(1297);
            4:       return t_cw'(651);
            5:       return t_cw'(326);
            6:       return t_cw'(163);
            7:       return t_cw'(81);
            8:       return t_cw'(41);
            9:       return t_cw'(20);
            10:      return t_cw'(10);
            11:      return t_cw'(5);
            12:      return t_cw'(3);
            13:      return t_cw'(1);
            default: return t_cw'(0);
        endcase
    endfunction

    function automatic logic signed [15:0] clamp_unit(input t_cw v);
        if (v > t_cw'(32767)) begin
            return 16'sd32767;
        end else if (v < -t_cw'(32767)) begin
            return -16'sd32767;
        end else begin
            return v[15:0];
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/erd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module erd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/erd_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none
module erd_cordic (
    input  logic               i_clk,
    input  logic [15:0]        i_phase,
    output logic signed [15:0] o_cos,
    output logic signed [15:0] o_sin
);

    logic [15:0]     w_sum;
    logic [15:0]     w_fold;
    logic            w_neg;
    erd_pkg::t_cw    r_x   [0:erd_pkg::STEPS];
    erd_pkg::t_cw    r_y   [0:erd_pkg::STEPS];
    erd_pkg::t_cw    r_z   [0:erd_pkg::STEPS];
    logic            r_neg [0:erd_pkg::STEPS];
    erd_pkg::t_cw    n_x   [1:erd_pkg::STEPS];
    erd_pkg::t_cw    n_y   [1:erd_pkg::STEPS];
    erd_pkg::t_cw    n_z   [1:erd_pkg::STEPS];
    erd_pkg::t_cw    w_xo;
    erd_pkg::t_cw    w_yo;

    always_comb begin
        w_sum  = i_phase + 16'd16384;
        w_neg  = w_sum[15];
        w_fold = w_neg ? (i_phase - 16'd32768) : i_phase;
    end

    always_comb begin
        for (int g = 0; g < erd_pkg::STEPS; g++) begin
            if (!r_z[g][erd_pkg::CW-1]) begin
                n_x[g+1] = r_x[g] - (r_y[g] >>> g);
                n_y[g+1] = r_y[g] + (r_x[g] >>> g);
                n_z[g+1] = r_z[g] - erd_pkg::angle_step(g);
            end else begin
                n_x[g+1] = r_x[g] + (r_y[g] >>> g);
                n_y[g+1] = r_y[g] - (r_x[g] >>> g);
                n_z[g+1] = r_z[g] + erd_pkg::angle_step(g);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]   <= erd_pkg::t_cw'(erd_pkg::CORDIC_X0);
        r_y[0]   <= '0;
        r_z[0]   <= {{(erd_pkg::CW-16){w_fold[15]}}, w_fold};
        r_neg[0] <= w_neg;
        for (int g = 1; g <= erd_pkg::STEPS; g++) begin
            r_x[g]   <= n_x[g];
            r_y[g]   <= n_y[g];
            r_z[g]   <= n_z[g];
            r_neg[g] <= r_neg[g-1];
        end
    end

    always_comb begin
        w_xo  = r_neg[erd_pkg::STEPS] ? -r_x[erd_pkg::STEPS] : r_x[erd_pkg::STEPS];
        w_yo  = r_neg[erd_pkg::STEPS] ? -r_y[erd_pkg::STEPS] : r_y[erd_pkg::STEPS];
        o_cos = erd_pkg::clamp_unit(w_xo);
        o_sin = erd_pkg::clamp_unit(w_yo);
    end

endmodule
`default_nettype wire

// ===== rtl/ewald_reciprocal_delta_core.sv =====
// A delta of a valid move kind and an evaluate walk the entries in use; commit and
// reject walk all 512 entries of the factor memories.
// One item at a time: each delta or evaluate walks the table at one entry a cycle
// through the read port of the factor memories.
// Reset is synchronous; afterwards a clear pass zeroes the factor memories
// with input ready low. The k-vector table is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "ewald_reciprocal_delta_core_assert.svh"
module ewald_reciprocal_delta_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [erd_pkg::KCOUNT_W-1:0]    i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [2:0]                      i_func,
    input  logic [8:0]                      i_k_index,
    input  logic [12:0]                     i_k_vector,
    input  logic [15:0]                     i_k_weight,
    input  logic signed [15:0]              i_charge,
    input  logic [1:0]                      i_move_kind,
    input  logic [15:0]                     i_old_x,
    input  logic [15:0]                     i_old_y,
    input  logic [15:0]                     i_old_z,
    input  logic [15:0]                     i_new_x,
    input  logic [15:0]                     i_new_y,
    input  logic [15:0]                     i_new_z,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [47:0]                     o_energy,
    output logic                            o_status
);

    localparam int AW = erd_pkg::ADDR_W;
    localparam int CW = erd_pkg::CMP_W;
    localparam logic [47:0] CAP = {48{1'b1}};

    erd_pkg::t_state r_state, n_state;
    logic [erd_pkg::KCOUNT_W-1:0] r_kcount;
    logic [2:0]         r_func;
    logic [1:0]         r_kind;
    logic signed [15:0] r_q;
    logic [15:0]        r_ox, r_oy, r_oz, r_nx, r_ny, r_nz;
    logic [CW-1:0]      r_len, r_cnt, n_len, w_n, w_kc;
    logic               w_accept, w_issue, w_clr, w_deliver, w_busy, w_load_ok;
    logic [erd_pkg::DLAT-1:0] r_dv;
    logic [AW-1:0]      r_didx [0:erd_pkg::DLAT-1];
    logic [erd_pkg::ELAT-1:0] r_ev;
    logic               r_cv;
    logic [AW-1:0]      r_cidx;
    logic [47:0]        r_energy;
    logic               r_stat;
    logic               r_out_valid;
    logic [47:0]        r_energy_out;
    logic               r_status_out;

    logic                     w_tab_we;
    logic [erd_pkg::TAB_W-1:0] w_tab;
    logic                     w_tr_we;
    logic [AW-1:0]            w_tr_waddr, w_tr_raddr;
    logic [erd_pkg::SF_W-1:0] w_tr_wdata, w_tr;
    logic                     w_cm_we;
    logic [erd_pkg::SF_W-1:0] w_cm_wdata, w_cm;

    logic signed [6:0]  w_ky_s, w_kz_s;
    logic [15:0]        w_kx16, w_ky16, w_kz16;
    logic [15:0]        r_ph_old, r_ph_new;
    logic signed [15:0] w_co, w_so, w_cn, w_sn, w_co_m, w_so_m, w_cn_m, w_sn_m;
    logic               w_use_old, w_use_new;
    logic signed [16:0] w_dc, w_ds;
    logic signed [32:0] w_pc, w_ps;
    logic signed [33:0] w_rc, w_rs;
    logic signed [18:0] r_dre, r_dim;
    logic signed [32:0] w_sre, w_sim;
    logic [31:0]        w_nre, w_nim;
    logic               w_dsat;

    logic signed [63:0] r_sq_re, r_sq_im;
    logic [15:0]        r_w1, r_w2;
    logic [63:0]        r_mag;
    logic [47:0]        r_phi, r_plo;
    logic [64:0]        w_term;
    logic [47:0]        r_term;
    logic               r_tsat;
    logic [48:0]        w_esum;

    erd_ram #(.WIDTH(erd_pkg::TAB_W), .DEPTH(erd_pkg::MAX_KVECTORS)) u_tab (
        .i_clk   (i_clk),
        .i_we    (w_tab_we),
        .i_waddr (i_k_index[AW-1:0]),
        .i_wdata ({i_k_weight, i_k_vector}),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (w_tab)
    );

    erd_ram #(.WIDTH(erd_pkg::SF_W), .DEPTH(erd_pkg::MAX_KVECTORS)) u_trial (
        .i_clk   (i_clk),
        .i_we    (w_tr_we),
        .i_waddr (w_tr_waddr),
        .i_wdata (w_tr_wdata),
        .i_raddr (w_tr_raddr),
        .o_rdata (w_tr)
    );

    erd_ram #(.WIDTH(erd_pkg::SF_W), .DEPTH(erd_pkg::MAX_KVECTORS)) u_commit (
        .i_clk   (i_clk),
        .i_we    (w_cm_we),
        .i_waddr (w_clr ? r_cnt[AW-1:0] : r_cidx),
        .i_wdata (w_cm_wdata),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (w_cm)
    );

    erd_cordic u_cordic_old (
        .i_clk   (i_clk),
        .i_phase (r_ph_old),
        .o_cos   (w_co),
        .o_sin   (w_so)
    );

    erd_cordic u_cordic_new (
        .i_clk   (i_clk),
        .i_phase (r_ph_new),
        .o_cos   (w_cn),
        .o_sin   (w_sn)
    );

    always_comb begin
        w_kc      = CW'(r_kcount);
        w_n       = (w_kc < CW'(erd_pkg::MAX_KVECTORS)) ? w_kc : CW'(erd_pkg::MAX_KVECTORS);
        w_load_ok = CW'(i_k_index) < w_n;
        w_busy    = (|r_dv) || (|r_ev) || r_cv;
        case (i_func)
            erd_pkg::FN_DELTA: begin
                n_len = (i_move_kind == erd_pkg::MK_MOVE || i_move_kind == erd_pkg::MK_INSERT
                         || i_move_kind == erd_pkg::MK_REMOVE) ? w_n : '0;
            end
            erd_pkg::FN_EVAL:   n_len = w_n;
            erd_pkg::FN_COMMIT: n_len = CW'(erd_pkg::MAX_KVECTORS);
            erd_pkg::FN_REJECT: n_len = CW'(erd_pkg::MAX_KVECTORS);
            default:            n_len = '0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            erd_pkg::S_CLEAR: if (r_cnt >= r_len) n_state = erd_pkg::S_IDLE;
            erd_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_func == erd_pkg::FN_LOAD) ? erd_pkg::S_DONE : erd_pkg::S_RUN;
                end
            end
            erd_pkg::S_RUN:   if (r_cnt >= r_len) n_state = erd_pkg::S_DRAIN;
            erd_pkg::S_DRAIN: if (!w_busy) n_state = erd_pkg::S_DONE;
            erd_pkg::S_DONE:  if (w_deliver) n_state = erd_pkg::S_IDLE;
            default:          n_state = erd_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = (r_state == erd_pkg::S_IDLE);
        w_issue    = (r_state == erd_pkg::S_RUN) && (r_cnt < r_len);
        w_clr      = (r_state == erd_pkg::S_CLEAR) && (r_cnt < r_len);
        w_deliver  = (r_state == erd_pkg::S_DONE) && (!r_out_valid || i_out_ready);
    end

    assign w_accept = i_in_valid && o_in_ready;
    assign w_tab_we = w_accept && (i_func == erd_pkg::FN_LOAD) && w_load_ok;

    // phase of one entry
    always_comb begin
        w_ky_s = $signed({2'b00, w_tab[8:4]}) - 7'(erd_pkg::MAX_K);
        w_kz_s = $signed({3'b000, w_tab[12:9]}) - 7'(erd_pkg::MAX_K);
        w_kx16 = {12'd0, w_tab[3:0]};
        w_ky16 = {{9{w_ky_s[6]}}, w_ky_s};
        w_kz16 = {{9{w_kz_s[6]}}, w_kz_s};
    end

    // delta per entry
    always_comb begin
        w_use_old = (r_kind == erd_pkg::MK_MOVE) || (r_kind == erd_pkg::MK_REMOVE);
        w_use_new = (r_kind == erd_pkg::MK_MOVE) || (r_kind == erd_pkg::MK_INSERT);
        w_co_m = w_use_old ? w_co : 16'sd0;
        w_so_m = w_use_old ? w_so : 16'sd0;
        w_cn_m = w_use_new ? w_cn : 16'sd0;
        w_sn_m = w_use_new ? w_sn : 16'sd0;
        w_dc   = {w_cn_m[15], w_cn_m} - {w_co_m[15], w_co_m};
        w_ds   = {w_sn_m[15], w_sn_m} - {w_so_m[15], w_so_m};
        w_pc   = r_q * w_dc;
        w_ps   = r_q * w_ds;
        w_rc   = {w_pc[32], w_pc} + 34'sd16384;
        w_rs   = {w_ps[32], w_ps} + 34'sd16384;
    end

    always_comb begin
        w_sre  = {w_tr[31], w_tr[31:0]} + {{14{r_dre[18]}}, r_dre};
        w_sim  = {w_tr[63], w_tr[63:32]} + {{14{r_dim[18]}}, r_dim};
        w_dsat = 1'b0;
        w_nre  = w_sre[31:0];
        w_nim  = w_sim[31:0];
        if (w_sre[32] != w_sre[31]) begin
            w_nre  = w_sre[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            w_dsat = 1'b1;
        end
        if (w_sim[32] != w_sim[31]) begin
            w_nim  = w_sim[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            w_dsat = 1'b1;
        end
    end

    // factor memory ports
    always_comb begin
        w_tr_raddr = (r_func == erd_pkg::FN_DELTA) ? r_didx[erd_pkg::DLAT-2] : r_cnt[AW-1:0];
        w_tr_we    = 1'b0;
        w_tr_waddr = r_cnt[AW-1:0];
        w_tr_wdata = '0;
        if (w_clr) begin
            w_tr_we = 1'b1;
        end else if (r_dv[erd_pkg::DLAT-1]) begin
            w_tr_we    = 1'b1;
            w_tr_waddr = r_didx[erd_pkg::DLAT-1];
            w_tr_wdata = {w_nim, w_nre};
        end else if (r_cv && r_func == erd_pkg::FN_REJECT) begin
            w_tr_we    = 1'b1;
            w_tr_waddr = r_cidx;
            w_tr_wdata = w_cm;
        end
        w_cm_we    = w_clr || (r_cv && r_func == erd_pkg::FN_COMMIT);
        w_cm_wdata = w_clr ? '0 : w_tr;
    end

    // energy term
    always_comb begin
        w_term = {1'b0, r_phi, 16'd0} + 65'(r_plo[47:16]);
        w_esum = {1'b0, r_energy} + {1'b0, r_term};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= erd_pkg::S_CLEAR;
            r_cnt       <= '0;
            r_len       <= CW'(erd_pkg::MAX_KVECTORS);
            r_dv        <= '0;
            r_ev        <= '0;
            r_cv        <= 1'b0;
            r_out_valid <= 1'b0;
            r_kcount    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_kcount <= i_cfg_data;
            end
            if (w_accept) begin
                r_cnt <= '0;
                r_len <= n_len;
            end else if (w_issue || w_clr) begin
                r_cnt <= r_cnt + 1'b1;
            end
            r_dv <= {r_dv[erd_pkg::DLAT-2:0], w_issue && (r_func == erd_pkg::FN_DELTA)};
            r_ev <= {r_ev[erd_pkg::ELAT-2:0], w_issue && (r_func == erd_pkg::FN_EVAL)};
            r_cv <= w_issue && (r_func == erd_pkg::FN_COMMIT || r_func == erd_pkg::FN_REJECT);
            if (w_deliver) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func   <= i_func;
            r_kind   <= i_move_kind;
            r_q      <= i_charge;
            r_ox     <= i_old_x;
            r_oy     <= i_old_y;
            r_oz     <= i_old_z;
            r_nx     <= i_new_x;
            r_ny     <= i_new_y;
            r_nz     <= i_new_z;
            r_energy <= '0;
            r_stat   <= (i_func == erd_pkg::FN_LOAD) && !w_load_ok;
        end else begin
            if (r_dv[erd_pkg::DLAT-1] && w_dsat) begin
                r_stat <= 1'b1;
            end
            if (r_ev[erd_pkg::ELAT-1]) begin
                if (w_esum > {1'b0, CAP}) begin
                    r_energy <= CAP;
                end else begin
                    r_energy <= w_esum[47:0];
                end
                if (r_tsat || (w_esum > {1'b0, CAP})) begin
                    r_stat <= 1'b1;
                end
            end
        end
        r_didx[0] <= r_cnt[AW-1:0];
        for (int j = 1; j < erd_pkg::DLAT; j++) begin
            r_didx[j] <= r_didx[j-1];
        end
        r_cidx   <= r_cnt[AW-1:0];
        r_ph_old <= w_kx16 * r_ox + w_ky16 * r_oy + w_kz16 * r_oz;
        r_ph_new <= w_kx16 * r_nx + w_ky16 * r_ny + w_kz16 * r_nz;
        r_dre    <= w_rc[33:15];
        r_dim    <= w_rs[33:15];
        r_sq_re  <= $signed(w_tr[31:0]) * $signed(w_tr[31:0]);
        r_sq_im  <= $signed(w_tr[63:32]) * $signed(w_tr[63:32]);
        r_w1     <= w_tab[28:13];
        r_mag    <= $unsigned(r_sq_re) + $unsigned(r_sq_im);
        r_w2     <= r_w1;
        r_phi    <= r_w2 * r_mag[63:32];
        r_plo    <= r_w2 * r_mag[31:0];
        if (w_term > {17'd0, CAP}) begin
            r_term <= CAP;
            r_tsat <= 1'b1;
        end else begin
            r_term <= w_term[47:0];
            r_tsat <= 1'b0;
        end
        if (w_deliver) begin
            r_energy_out <= r_energy;
            r_status_out <= r_stat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_energy    = r_energy_out;
    assign o_status    = r_status_out;

    `ERD_ASSERT_NEXT(a_delta_issue, w_issue && (r_func == erd_pkg::FN_DELTA), r_dv[0])
    `ERD_ASSERT_IMP(a_one_path, |r_dv, !(|r_ev) && !r_cv)
    `ERD_ASSERT_IMP(a_done_empty, r_state == erd_pkg::S_DONE, !w_busy)

endmodule
`default_nettype wire

// ===== dv/ewald_reciprocal_delta_core_checker.sv =====
`timescale 1ns / 1ps
module ewald_reciprocal_delta_core_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [9:0]         i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [2:0]         i_func,
    input  logic [8:0]         i_k_index,
    input  logic [12:0]        i_k_vector,
    input  logic [15:0]        i_k_weight,
    input  logic signed [15:0] i_charge,
    input  logic [1:0]         i_move_kind,
    input  logic [15:0]        i_old_x,
    input  logic [15:0]        i_old_y,
    input  logic [15:0]        i_old_z,
    input  logic [15:0]        i_new_x,
    input  logic [15:0]        i_new_y,
    input  logic [15:0]        i_new_z,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [47:0]        i_energy,
    input  logic               i_status,
    output int                 o_fails,
    output int                 o_pending,
    output int                 o_results
);
    import erd_pkg::*;

    localparam int ROT[14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};
    localparam logic [63:0] ECAP = (64'd1 << 48) - 64'd1;

    typedef struct packed {
        logic [47:0] energy;
        logic        status;
    } t_result;

    logic [9:0]  k_count_q;
    logic [3:0]  kx_tab [MAX_KVECTORS];
    logic [4:0]  ky_tab [MAX_KVECTORS];
    logic [4:0]  kz_tab [MAX_KVECTORS];
    logic [15:0] wt_tab [MAX_KVECTORS];
    int          sf_re  [MAX_KVECTORS];
    int          sf_im  [MAX_KVECTORS];
    int          tr_re  [MAX_KVECTORS];
    int          tr_im  [MAX_KVECTORS];
    t_result     energy_q [$];

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
        o_fails++;
    endtask

    function automatic void cos_sin(input logic [15:0] p, output int c, output int s);
        longint x = 19898;
        longint y = 0;
        longint z;
        longint nx;
        logic neg = 1'b0;
        logic [15:0] pp = p;
        logic [15:0] probe = p + 16'd16384;
        if (probe[15]) begin
            pp = p - 16'd32768;
            neg = 1'b1;
        end
        z = longint'($signed(pp));
        for (int i = 0; i < 14; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= ROT[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += ROT[i];
            end
            x = nx;
        end
        if (neg) begin
            x = -x;
            y = -y;
        end
        c = (x > 32767) ? 32767 : (x < -32767) ? -32767 : int'(x);
        s = (y > 32767) ? 32767 : (y < -32767) ? -32767 : int'(y);
    endfunction

    function automatic logic [15:0] phase_of(input int k, input logic [15:0] x,
                                            input logic [15:0] y, input logic [15:0] z);
        int sum;
        sum = int'(kx_tab[k]) * int'({16'b0, x}) + (int'(ky_tab[k]) - MAX_K) * int'({16'b0, y})
            + (int'(kz_tab[k]) - MAX_K) * int'({16'b0, z});
        return sum[15:0];
    endfunction

    function automatic int sat_add(input int a, input longint d, inout logic sat);
        longint r;
        r = longint'(a) + d;
        if (r > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'h7FFFFFFF;
        end
        if (r < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'h80000000;
        end
        return int'(r);
    endfunction

    function automatic t_result predict_energy();
        t_result res = '0;
        int n = (k_count_q < MAX_KVECTORS) ? int'(k_count_q) : MAX_KVECTORS;
        longint q;
        int co, so, cn, sn;
        logic use_old, use_new, sat;
        longint re, im;
        logic [63:0] mag, w, term, acc;
        case (i_func)
            FN_LOAD: begin
                if (int'(i_k_index) >= n) begin
                    res.status = 1'b1;
                end else begin
                    kx_tab[i_k_index] = i_k_vector[3:0];
                    ky_tab[i_k_index] = i_k_vector[8:4];
                    kz_tab[i_k_index] = {1'b0, i_k_vector[12:9]};
                    wt_tab[i_k_index] = i_k_weight;
                end
            end
            FN_DELTA: begin
                q = longint'(i_charge);
                use_old = (i_move_kind == MK_MOVE) || (i_move_kind == MK_REMOVE);
                use_new = (i_move_kind == MK_MOVE) || (i_move_kind == MK_INSERT);
                sat = 1'b0;
                for (int k = 0; k < n && (use_old || use_new); k++) begin
                    co = 0; so = 0; cn = 0; sn = 0;
                    if (use_old) cos_sin(phase_of(k, i_old_x, i_old_y, i_old_z), co, so);
                    if (use_new) cos_sin(phase_of(k, i_new_x, i_new_y, i_new_z), cn, sn);
                    tr_re[k] = sat_add(tr_re[k], (q * longint'(cn - co) + 16384) >>> 15, sat);
                    tr_im[k] = sat_add(tr_im[k], (q * longint'(sn - so) + 16384) >>> 15, sat);
                end
                res.status = sat;
            end
            FN_EVAL: begin
                acc = 0;
                for (int k = 0; k < n; k++) begin
                    re = tr_re[k];
                    im = tr_im[k];
                    mag = 64'(re * re) + 64'(im * im);
                    w = {48'b0, wt_tab[k]};
                    term = ((w * (mag >> 32)) << 16) + ((w * {32'b0, mag[31:0]}) >> 16);
                    if (term > ECAP) begin
                        term = ECAP;
                        res.status = 1'b1;
                    end
                    if (acc + term > ECAP) begin
                        acc = ECAP;
                        res.status = 1'b1;
                    end else begin
                        acc += term;
                    end
                end
                res.energy = acc[47:0];
            end
            FN_COMMIT: begin
                sf_re = tr_re;
                sf_im = tr_im;
            end
            FN_REJECT: begin
                tr_re = sf_re;
                tr_im = sf_im;
            end
            default: ;
        endcase
        return res;
    endfunction

    initial begin
        o_fails = 0;
        o_pending = 0;
        o_results = 0;
    end

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            k_count_q = '0;
            for (int k = 0; k < MAX_KVECTORS; k++) begin
                sf_re[k] = 0; sf_im[k] = 0; tr_re[k] = 0; tr_im[k] = 0;
                kx_tab[k] = '0; ky_tab[k] = '0; kz_tab[k] = '0; wt_tab[k] = '0;
            end
            energy_q.delete();
        end else begin
            if (i_cfg_we) k_count_q = i_cfg_data;
            if (i_out_valid && i_out_ready) begin
                o_results++;
                if (energy_q.size() == 0) begin
                    report("unexpected result", {16'b0, i_energy}, 0);
                end else begin
                    want = energy_q.pop_front();
                    if (i_energy !== want.energy) report("energy", i_energy, want.energy);
                    if (i_status !== want.status) report("status", i_status, want.status);
                end
            end
            if (i_in_valid && i_in_ready) energy_q = {energy_q, predict_energy()};
        end
        o_pending = energy_q.size();
    end
endmodule

// ===== dv/ewald_reciprocal_delta_core_tb.sv =====
`timescale 1ns / 1ps
module ewald_reciprocal_delta_core_tb;
    import erd_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [9:0]         i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [2:0]         i_func = '0;
    logic [8:0]         i_k_index = '0;
    logic [12:0]        i_k_vector = '0;
    logic [15:0]        i_k_weight = '0;
    logic signed [15:0] i_charge = '0;
    logic [1:0]         i_move_kind = '0;
    logic [15:0]        i_old_x = '0, i_old_y = '0, i_old_z = '0;
    logic [15:0]        i_new_x = '0, i_new_y = '0, i_new_z = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [47:0]        o_energy;
    logic               o_status;

    int   fails, pending, results;
    int   sent = 0;
    int   idle_cycles = 0;
    int   stall_left = 0;
    int   eff_count = 0;
    logic calm = 1'b0;
    logic gappy = 1'b1;
    logic loaded [MAX_KVECTORS];

    always #2 i_clk = ~i_clk;

    ewald_reciprocal_delta_core dut (.*);

    ewald_reciprocal_delta_core_checker chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_data, .i_in_valid, .i_in_ready(o_in_ready),
        .i_func, .i_k_index, .i_k_vector, .i_k_weight, .i_charge, .i_move_kind,
        .i_old_x, .i_old_y, .i_old_z, .i_new_x, .i_new_y, .i_new_z,
        .i_out_valid(o_out_valid), .i_out_ready, .i_energy(o_energy), .i_status(o_status),
        .o_fails(fails), .o_pending(pending), .o_results(results)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || calm) begin
            i_out_ready <= i_rst_n;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 11) == 0) begin
            i_out_ready <= 1'b0;
            stall_left <= $urandom_range(0, 8);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [15:0] pick_pos();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_charge();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic transfer(input logic [2:0] fn, input logic [8:0] idx, input logic [12:0] vec,
                            input logic [15:0] w, input logic [15:0] q, input logic [1:0] kind,
                            input logic [15:0] ox, input logic [15:0] oy, input logic [15:0] oz,
                            input logic [15:0] nx, input logic [15:0] ny, input logic [15:0] nz);
        if (gappy && !calm && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= fn; i_k_index <= idx; i_k_vector <= vec; i_k_weight <= w;
        i_charge <= q; i_move_kind <= kind;
        i_old_x <= ox; i_old_y <= oy; i_old_z <= oz;
        i_new_x <= nx; i_new_y <= ny; i_new_z <= nz;
        do @(negedge i_clk); while (!o_in_ready);
        @(posedge i_clk);
        sent++;
        if (fn == FN_LOAD && int'(idx) < eff_count) loaded[idx] = 1'b1;
    endtask

    task automatic send_load(input logic [8:0] idx, input logic [12:0] vec, input logic [15:0] w);
        transfer(FN_LOAD, idx, vec, w, 16'($urandom), 2'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic send_delta(input logic [15:0] q, input logic [1:0] kind);
        transfer(FN_DELTA, 9'($urandom), 13'($urandom), 16'($urandom), q, kind,
                 pick_pos(), pick_pos(), pick_pos(), pick_pos(), pick_pos(), pick_pos());
    endtask

    task automatic send_op(input logic [2:0] fn);
        transfer(fn, 9'($urandom), 13'($urandom), 16'($urandom), 16'($urandom), 2'($urandom),
                 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom));
    endtask

    // drain, then write the count and fill every entry the walk will read
    task automatic set_count(input logic [9:0] v);
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        eff_count = (v > MAX_KVECTORS) ? MAX_KVECTORS : int'(v);
        for (int k = 0; k < eff_count; k++) begin
            if (!loaded[k]) send_load(9'(k), 13'($urandom), 16'($urandom));
        end
    endtask

    task automatic random_phase(input int items);
        int pick;
        for (int j = 0; j < items; j++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                repeat ($urandom_range(1, 3)) send_delta(pick_charge(), 2'($urandom_range(0, 2)));
                send_op(FN_EVAL);
                send_op($urandom_range(0, 1) ? FN_COMMIT : FN_REJECT);
            end else if (pick < 70) begin
                send_op(FN_EVAL);
            end else if (pick < 78) begin
                send_load($urandom_range(0, 3) == 0 || eff_count == 0 ? 9'($urandom)
                          : 9'($urandom_range(0, eff_count - 1)),
                          13'($urandom), $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom));
            end else if (pick < 84) begin
                send_delta(pick_charge(), 2'($urandom));
            end else if (pick < 90) begin
                send_op(3'($urandom_range(5, 7)));
            end else begin
                send_op($urandom_range(0, 1) ? FN_COMMIT : FN_REJECT);
            end
        end
    endtask

    initial begin
        logic [9:0] plan [12] = '{3, 1, 8, 512, 6, 1023, 2, 0, 16, 5, 512, 4};
        for (int k = 0; k < MAX_KVECTORS; k++) loaded[k] = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_count(10'd4);
        send_load(9'd0, 13'h0000, 16'h0000);
        send_load(9'd1, 13'h1FFF, 16'hFFFF);
        send_load(9'd2, 13'h1111, 16'h8000);
        send_load(9'd3, 13'h0EEE, 16'hFFFF);
        send_load(9'd4, 13'h1234, 16'h1234);
        send_load(9'd511, 13'h1FFF, 16'hFFFF);
        transfer(FN_DELTA, 0, 0, 0, 16'h8000, MK_MOVE, 0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        transfer(FN_DELTA, 0, 0, 0, 16'h7FFF, MK_INSERT, 0, 0, 0, 16'h4000, 16'h8000, 16'hC000);
        transfer(FN_DELTA, 0, 0, 0, 16'h7FFF, MK_REMOVE, 16'hFFFF, 0, 16'h8000, 0, 0, 0);
        transfer(FN_DELTA, 0, 0, 0, 16'h7FFF, 2'd3, 16'h1234, 16'h5678, 16'h9ABC, 0, 0, 0);
        send_op(FN_EVAL);
        send_op(FN_COMMIT);
        send_delta(16'h8000, MK_MOVE);
        send_op(FN_EVAL);
        send_op(FN_REJECT);
        send_op(FN_EVAL);
        send_op(3'd5);
        send_op(3'd6);
        send_op(3'd7);

        foreach (plan[p]) begin
            gappy = (p % 3) != 1;
            calm = (p == 11);
            set_count(plan[p]);
            random_phase(plan[p] >= 10'd512 ? 8 : (plan[p] == 10'd0 ? 25 : 23));
        end

        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("covered %0d transfers in, %0d results, %0d k-count settings incl. 0 and 1023",
                 sent, results, $size(plan) + 1);
        if (fails == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
